// ===== src/lru_page_replacement_macros.svh =====
// ----------------------------------------------------------------------------
// lru page replacement assertion macros
// shared concurrent assertion forms, clocked on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define LRUPR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int FRAMES_DEF    = 8;
   localparam int PAGE_BITS_DEF = 8;

   localparam int PAGE_NUMBER_W  = 8;
   localparam int FRAME_COUNT_W  = 4;
   localparam int FRAME_INDEX_W  = 3;
   localparam int EVICTED_PAGE_W = 8;
   localparam int FAULT_TOTAL_W  = 32;

   localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 4'd8;
   localparam logic [FAULT_TOTAL_W-1:0] FAULT_TOTAL_MAX   = '1;

   typedef struct packed {
      logic load;
      logic lookup;
      logic fetch;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic hit_found;
      logic empty_found;
      logic scan_done;
   } status_type;

endpackage

// ===== src/lrupr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrupr_ctrl
// sequencer: accept, lookup, victim scan, commit into the result register
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lrupr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lrupr_pkg::status_type status,
   output lrupr_pkg::cmd_type    cmd
);
   import lrupr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.hit_found) begin
               cmd.fetch = 1'b1;
               state_in  = ST_COMMIT;
            end else if (status.empty_found || status.scan_done) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `LRUPR_ASSERT_NEXT(a_one_word_at_a_time, req_valid && req_ready, !req_ready, "second word taken in flight")
   `LRUPR_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp_valid, "commit without result")
   `LRUPR_ASSERT_NEXT(a_result_from_commit, !rsp_valid_ff && state_ff != ST_COMMIT, !rsp_valid_ff, "result without commit")

endmodule

// ===== src/lrupr_dpath.sv =====
// ----------------------------------------------------------------------------
// lrupr_dpath
// frame table, recency ranks, parallel match, victim scan and result register
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lrupr_dpath #(
   parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_enable,
   input  logic [lrupr_pkg::FRAME_COUNT_W-1:0]       csr_write_data,
   input  logic [lrupr_pkg::PAGE_NUMBER_W-1:0]       req_page_number,
   input  lrupr_pkg::cmd_type                        cmd,
   output lrupr_pkg::status_type                     status,
   output logic                                      rsp_hit,
   output logic                                      rsp_fault,
   output logic [lrupr_pkg::FRAME_INDEX_W-1:0]       rsp_frame_index,
   output logic                                      rsp_evicted_valid,
   output logic [lrupr_pkg::EVICTED_PAGE_W-1:0]      rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_TOTAL_W-1:0]       rsp_fault_total
);
   import lrupr_pkg::*;

   localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W  = $clog2(FRAMES + 1);
   localparam int RANK_W = IDX_W;

   logic [FRAME_COUNT_W-1:0]  frame_count_ff;
   logic [PAGE_BITS-1:0]      page_ff;
   logic [PAGE_BITS-1:0]      frame_page_ff [FRAMES];
   logic [FRAMES-1:0]         frame_valid_ff;
   logic [RANK_W-1:0]         rank_ff [FRAMES];
   logic                      hit_found_ff, empty_found_ff;
   logic [IDX_W-1:0]          hit_idx_ff, empty_idx_ff, victim_ff;
   logic [CNT_W-1:0]          scan_idx_ff;
   logic [RANK_W-1:0]         limit_ff;
   logic [FAULT_TOTAL_W-1:0]  fault_total_ff, fault_total_in;
   logic                      out_hit_ff, out_ev_valid_ff;
   logic [FRAME_INDEX_W-1:0]  out_frame_ff;
   logic [EVICTED_PAGE_W-1:0] out_ev_page_ff;
   logic [FAULT_TOTAL_W-1:0]  out_ft_ff;

   logic [CNT_W-1:0]  used_cnt;
   logic [FRAMES-1:0] in_use;
   logic              hit_any, empty_any;
   logic [IDX_W-1:0]  hit_sel, empty_sel;
   logic [IDX_W-1:0]  rank_addr, target_idx;
   logic [RANK_W-1:0] rank_rd;
   logic              is_fill, is_replace;

   // frames in use: zero counts as one, large values clip to the table size
   always_comb begin
      if (frame_count_ff == '0) begin
         used_cnt = CNT_W'(1);
      end else if (int'(frame_count_ff) > FRAMES) begin
         used_cnt = CNT_W'(FRAMES);
      end else begin
         used_cnt = CNT_W'(frame_count_ff);
      end
      for (int k = 0; k < FRAMES; k++) begin
         in_use[k] = (k < int'(used_cnt));
      end
   end

   // parallel match and first empty frame, lowest index wins
   always_comb begin
      hit_any   = 1'b0;
      hit_sel   = '0;
      empty_any = 1'b0;
      empty_sel = '0;
      for (int k = FRAMES - 1; k >= 0; k--) begin
         if (in_use[k] && frame_valid_ff[k] && frame_page_ff[k] == page_ff) begin
            hit_any = 1'b1;
            hit_sel = IDX_W'(k);
         end
         if (in_use[k] && !frame_valid_ff[k]) begin
            empty_any = 1'b1;
            empty_sel = IDX_W'(k);
         end
      end
   end

   assign rank_addr = cmd.fetch ? hit_idx_ff : scan_idx_ff[IDX_W-1:0];
   assign rank_rd   = rank_ff[rank_addr];

   assign is_fill    = !hit_found_ff && empty_found_ff;
   assign is_replace = !hit_found_ff && !empty_found_ff;
   assign target_idx = hit_found_ff ? hit_idx_ff : (empty_found_ff ? empty_idx_ff : victim_ff);

   assign fault_total_in = (fault_total_ff == FAULT_TOTAL_MAX) ? fault_total_ff
                                                               : fault_total_ff + FAULT_TOTAL_W'(1);

   assign status.hit_found   = hit_found_ff;
   assign status.empty_found = empty_found_ff;
   assign status.scan_done   = (scan_idx_ff >= used_cnt);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
         frame_valid_ff <= '0;
         fault_total_ff <= '0;
         for (int k = 0; k < FRAMES; k++) begin
            rank_ff[k] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            frame_count_ff <= csr_write_data;
         end
         if (cmd.commit) begin
            frame_valid_ff[target_idx] <= 1'b1;
            if (!hit_found_ff) begin
               fault_total_ff <= fault_total_in;
            end
            for (int k = 0; k < FRAMES; k++) begin
               if (IDX_W'(k) == target_idx) begin
                  rank_ff[k] <= '0;
               end else if (frame_valid_ff[k] && (is_fill || rank_ff[k] < limit_ff)) begin
                  rank_ff[k] <= rank_ff[k] + RANK_W'(1);
               end
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= PAGE_BITS'(req_page_number);
      end
      if (cmd.lookup) begin
         hit_found_ff   <= hit_any;
         hit_idx_ff     <= hit_sel;
         empty_found_ff <= empty_any;
         empty_idx_ff   <= empty_sel;
         scan_idx_ff    <= CNT_W'(1);
         victim_ff      <= '0;
         limit_ff       <= rank_ff[0];
      end
      if (cmd.fetch) begin
         limit_ff <= rank_rd;
      end
      if (cmd.step) begin
         if (rank_rd > limit_ff) begin
            victim_ff <= rank_addr;
            limit_ff  <= rank_rd;
         end
         scan_idx_ff <= scan_idx_ff + CNT_W'(1);
      end
      if (cmd.commit) begin
         if (!hit_found_ff) begin
            frame_page_ff[target_idx] <= page_ff;
         end
         out_hit_ff      <= hit_found_ff;
         out_frame_ff    <= FRAME_INDEX_W'(target_idx);
         out_ev_valid_ff <= is_replace;
         out_ev_page_ff  <= is_replace ? EVICTED_PAGE_W'(frame_page_ff[victim_ff]) : '0;
         out_ft_ff       <= hit_found_ff ? fault_total_ff : fault_total_in;
      end
   end

   assign rsp_hit           = out_hit_ff;
   assign rsp_fault         = !out_hit_ff;
   assign rsp_frame_index   = out_frame_ff;
   assign rsp_evicted_valid = out_ev_valid_ff;
   assign rsp_evicted_page  = out_ev_page_ff;
   assign rsp_fault_total   = out_ft_ff;

   `LRUPR_ASSERT_NEXT(a_total_never_drops, 1'b1, fault_total_ff >= $past(fault_total_ff), "fault total decreased")
   `LRUPR_ASSERT_NEXT(a_fault_counts, cmd.commit && !hit_found_ff, fault_total_ff != $past(fault_total_ff) || $past(fault_total_ff) == FAULT_TOTAL_MAX, "fault not counted")
   `LRUPR_ASSERT_NEXT(a_target_most_recent, cmd.commit, rank_ff[$past(target_idx)] == '0 && frame_valid_ff[$past(target_idx)], "target frame not most recent")

endmodule

// ===== src/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement: fully associative lru frame table, one word per reference;
// a hit or a fill goes from accept through lookup to commit without stepping the victim
// scan, a replacement scans the frames in use one frame per cycle; one word in flight at a time
// reset clears all frames, ranks and the fault total, and sets the frame count to 8
// ----------------------------------------------------------------------------
module lru_page_replacement #(
   parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [lrupr_pkg::FRAME_COUNT_W-1:0]  csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lrupr_pkg::PAGE_NUMBER_W-1:0]  req_page_number,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic                                 rsp_fault,
   output logic [lrupr_pkg::FRAME_INDEX_W-1:0]  rsp_frame_index,
   output logic                                 rsp_evicted_valid,
   output logic [lrupr_pkg::EVICTED_PAGE_W-1:0] rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_TOTAL_W-1:0]  rsp_fault_total
);
   import lrupr_pkg::*;

   cmd_type    cmd;
   status_type status;

   lrupr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrupr_dpath #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_page_number   (req_page_number),
      .cmd               (cmd),
      .status            (status),
      .rsp_hit           (rsp_hit),
      .rsp_fault         (rsp_fault),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

endmodule

// ===== bench/lru_page_replacement_tb.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_tb
// drives page references into the lru frame table and checks every response
// word against a predictor that tracks frames, ranks and the fault total;
// frame counts are written between drained phases, with random gaps and stalls
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NFRAMES      = lrupr_pkg::FRAMES_DEF;
   localparam int SETTLE       = 16;
   localparam int IDLE_LIMIT   = 4000;
   localparam int PHASE_ITEMS  = 88;
   localparam int HOT_SIZE     = 12;

   typedef logic [lrupr_pkg::PAGE_NUMBER_W-1:0] page_type;

   typedef struct packed {
      logic                                 hit;
      logic                                 fault;
      logic [lrupr_pkg::FRAME_INDEX_W-1:0]  frame_index;
      logic                                 evicted_valid;
      logic [lrupr_pkg::EVICTED_PAGE_W-1:0] evicted_page;
      logic [lrupr_pkg::FAULT_TOTAL_W-1:0]  fault_total;
   } lookup_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 csr_write_enable = 1'b0;
   logic [lrupr_pkg::FRAME_COUNT_W-1:0]  csr_write_data = '0;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   page_type                             req_page_number = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b1;
   logic                                 rsp_hit;
   logic                                 rsp_fault;
   logic [lrupr_pkg::FRAME_INDEX_W-1:0]  rsp_frame_index;
   logic                                 rsp_evicted_valid;
   logic [lrupr_pkg::EVICTED_PAGE_W-1:0] rsp_evicted_page;
   logic [lrupr_pkg::FAULT_TOTAL_W-1:0]  rsp_fault_total;

   // predictor state
   page_type                            frame_pg  [NFRAMES];
   logic                                frame_vld [NFRAMES];
   int unsigned                         frame_age [NFRAMES];
   logic [lrupr_pkg::FAULT_TOTAL_W-1:0] faults_seen;
   logic [lrupr_pkg::FRAME_COUNT_W-1:0] frames_cfg;

   page_type   page_q[$];
   lookup_type lookup_q[$];
   page_type   hot_pages[HOT_SIZE];
   int         err_cnt = 0;
   int         send_gap = 0;
   int         stall_left = 0;
   int         idle_cycles = 0;
   bit         calm = 1'b0;

   lru_page_replacement dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_fault         (rsp_fault),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

   always #1 clock = ~clock;

   function automatic int frames_in_use();
      int n;
      n = int'(frames_cfg);
      if (n == 0) n = 1;
      if (n > NFRAMES) n = NFRAMES;
      return n;
   endfunction

   // ages every valid frame other than f whose rank is below the limit, or every valid one when all is set
   function automatic void make_recent(int f, int unsigned limit, bit all);
      for (int k = 0; k < NFRAMES; k++) begin
         if (k != f && frame_vld[k] && (all || frame_age[k] < limit))
            frame_age[k]++;
      end
      frame_age[f] = 0;
   endfunction

   function automatic lookup_type resolve_page(page_type page);
      lookup_type res;
      int         used;
      int         f;
      bit         found;
      used  = frames_in_use();
      f     = 0;
      found = 1'b0;
      res   = '0;
      for (int k = 0; k < used && !found; k++) begin
         if (frame_vld[k] && frame_pg[k] == page) begin
            f = k;
            found = 1'b1;
         end
      end
      if (found) begin
         res.hit = 1'b1;
         make_recent(f, frame_age[f], 1'b0);
      end else begin
         for (int k = 0; k < used && !found; k++) begin
            if (!frame_vld[k]) begin
               f = k;
               found = 1'b1;
            end
         end
         if (found) begin
            frame_vld[f] = 1'b1;
            frame_pg[f]  = page;
            frame_age[f] = 0;
            make_recent(f, 0, 1'b1);
         end else begin
            f = 0;
            for (int k = 1; k < used; k++) begin
               if (frame_age[k] > frame_age[f]) f = k;
            end
            res.evicted_valid = 1'b1;
            res.evicted_page  = frame_pg[f];
            frame_pg[f] = page;
            make_recent(f, frame_age[f], 1'b0);
         end
         if (faults_seen != lrupr_pkg::FAULT_TOTAL_MAX) faults_seen++;
      end
      res.fault       = ~res.hit;
      res.frame_index = f[lrupr_pkg::FRAME_INDEX_W-1:0];
      res.fault_total = faults_seen;
      return res;
   endfunction

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         err_cnt++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            lookup_q.push_back(resolve_page(req_page_number));
            send_gap = calm ? 0 : rand_gap();
         end
         if (req_valid && !req_ready) begin
            // hold the word until taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (page_q.size() > 0) begin
            req_page_number <= page_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      lookup_type exp_word;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (lookup_q.size() == 0) begin
               $error("response word with nothing expected");
               err_cnt++;
            end else begin
               exp_word = lookup_q.pop_front();
               check_field("hit", 32'(exp_word.hit), 32'(rsp_hit));
               check_field("fault", 32'(exp_word.fault), 32'(rsp_fault));
               check_field("frame_index", 32'(exp_word.frame_index), 32'(rsp_frame_index));
               check_field("evicted_valid", 32'(exp_word.evicted_valid),
                           32'(rsp_evicted_valid));
               check_field("evicted_page", 32'(exp_word.evicted_page), 32'(rsp_evicted_page));
               check_field("fault_total", exp_word.fault_total, rsp_fault_total);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left = rand_gap();
            rsp_ready <= (stall_left == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // checked at the falling edge, after the driver and monitor have settled
   task automatic drain();
      while (page_q.size() > 0 || req_valid || lookup_q.size() > 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_frame_count(logic [lrupr_pkg::FRAME_COUNT_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      frames_cfg = value;
   endtask

   initial begin
      logic [lrupr_pkg::FRAME_COUNT_W-1:0] counts[14];
      page_type directed[21];
      int       span;

      for (int k = 0; k < NFRAMES; k++) begin
         frame_pg[k]  = '0;
         frame_vld[k] = 1'b0;
         frame_age[k] = 0;
      end
      faults_seen = '0;
      frames_cfg  = lrupr_pkg::FRAME_COUNT_RESET;
      counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd2, 4'd8,
                 4'd5, 4'd7, 4'd6, 4'd4, 4'd1, 4'd8};
      // fill all frames, hit, then replace in lru order
      directed = '{8'h00, 8'hff, 8'haa, 8'h55, 8'h0f, 8'hf0, 8'h01, 8'h80,
                   8'haa, 8'h00, 8'h33, 8'h80, 8'h44, 8'hff, 8'h33, 8'h01,
                   8'h7e, 8'h81, 8'h00, 8'h00, 8'hfe};
      for (int i = 0; i < HOT_SIZE; i++) hot_pages[i] = page_type'($urandom_range(0, 255));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      calm = 1'b1;
      foreach (directed[i]) page_q.push_back(directed[i]);
      drain();

      foreach (counts[p]) begin
         write_frame_count(counts[p]);
         calm = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < 3; i++)
            hot_pages[$urandom_range(0, HOT_SIZE-1)] = page_type'($urandom_range(0, 255));
         span = frames_in_use() + 3;
         if (span > HOT_SIZE) span = HOT_SIZE;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 75)
               page_q.push_back(hot_pages[$urandom_range(0, span-1)]);
            else
               page_q.push_back(page_type'($urandom_range(0, 255)));
         end
         drain();
      end

      if (err_cnt == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
